// ===== rtl/toroidal_life_generation_engine_macros.svh =====
// assertion macros for the checker file
`ifndef TOROIDAL_LIFE_GENERATION_ENGINE_MACROS_SVH
`define TOROIDAL_LIFE_GENERATION_ENGINE_MACROS_SVH

// property that holds in the same cycle
`define TLG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tlg assertion failed");

// consequent checked in the cycle after the antecedent
`define TLG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tlg assertion failed");

`endif

// ===== rtl/tlg_pkg.sv =====
// shared types, constants and the life rule for the generation engine
`default_nettype none

package tlg_pkg;

  localparam int unsigned DefaultMaxRows    = 64;
  localparam int unsigned DefaultMaxColumns = 64;

  localparam int unsigned CfgWidth    = 7;
  localparam int unsigned RowWidth    = 6;
  localparam int unsigned ColumnWidth = 6;

  localparam logic [CfgWidth-1:0] CfgCountReset = 7'd64;

  localparam logic [3:0] SurviveCount = 4'd2;
  localparam logic [3:0] BirthCount   = 4'd3;

  typedef enum logic {
    CfgRows    = 1'b0,
    CfgColumns = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OpWrite   = 2'd0,
    OpRead    = 2'd1,
    OpAdvance = 2'd2,
    OpClear   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StCellRd,
    StCellAct,
    StGenLast,
    StGenFirst,
    StGenPrime,
    StGenRow,
    StClear,
    StFinish
  } ctrl_state_e;

  typedef enum logic [2:0] {
    RdCell,
    RdLastRow,
    RdFirstRow,
    RdSecondRow,
    RdAhead
  } rd_src_e;

  typedef enum logic [1:0] {
    WrNone,
    WrZero,
    WrCell,
    WrGen
  } wr_src_e;

  typedef struct packed {
    logic    take;
    logic    cnt_clr;
    logic    cnt_inc;
    rd_src_e rd_src;
    wr_src_e wr_src;
    logic    win_prev;
    logic    win_first;
    logic    win_shift;
    logic    res_cell;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic sweep_end;
    logic row_end;
    logic out_free;
  } sts_t;

  function automatic logic life_next(input logic alive, input logic [3:0] count);
    logic res;
    if (alive) begin
      res = (count == SurviveCount) || (count == BirthCount);
    end else begin
      res = (count == BirthCount);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tlg_ram.sv =====
// generic one-write one-read ram with registered read data
`default_nettype none

module tlg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/tlg_ctrl.sv =====
// sequencer for cell access, clear sweeps and generation row passes
`default_nettype none

module tlg_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [1:0]   op_i,
  input  wire tlg_pkg::sts_t sts_i,
  output tlg_pkg::cmd_t     cmd_o
);

  tlg_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlg_pkg::StInit;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tlg_pkg::StInit: begin
        cmd_o.wr_src  = tlg_pkg::WrZero;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.sweep_end) begin
          state_d = tlg_pkg::StIdle;
        end
      end
      tlg_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take    = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          case (tlg_pkg::op_e'(op_i))
            tlg_pkg::OpWrite:   state_d = tlg_pkg::StCellRd;
            tlg_pkg::OpRead:    state_d = tlg_pkg::StCellRd;
            tlg_pkg::OpAdvance: state_d = tlg_pkg::StGenLast;
            tlg_pkg::OpClear:   state_d = tlg_pkg::StClear;
            default:            state_d = tlg_pkg::StIdle;
          endcase
        end
      end
      tlg_pkg::StCellRd: begin
        cmd_o.rd_src = tlg_pkg::RdCell;
        state_d      = tlg_pkg::StCellAct;
      end
      tlg_pkg::StCellAct: begin
        if (sts_i.op == tlg_pkg::OpWrite) begin
          cmd_o.wr_src = tlg_pkg::WrCell;
        end else begin
          cmd_o.res_cell = 1'b1;
        end
        state_d = tlg_pkg::StFinish;
      end
      tlg_pkg::StGenLast: begin
        cmd_o.rd_src = tlg_pkg::RdLastRow;
        state_d      = tlg_pkg::StGenFirst;
      end
      tlg_pkg::StGenFirst: begin
        cmd_o.rd_src   = tlg_pkg::RdFirstRow;
        cmd_o.win_prev = 1'b1;
        state_d        = tlg_pkg::StGenPrime;
      end
      tlg_pkg::StGenPrime: begin
        cmd_o.rd_src    = tlg_pkg::RdSecondRow;
        cmd_o.win_first = 1'b1;
        cmd_o.cnt_clr   = 1'b1;
        state_d         = tlg_pkg::StGenRow;
      end
      tlg_pkg::StGenRow: begin
        cmd_o.rd_src    = tlg_pkg::RdAhead;
        cmd_o.wr_src    = tlg_pkg::WrGen;
        cmd_o.win_shift = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        if (sts_i.row_end) begin
          state_d = tlg_pkg::StFinish;
        end
      end
      tlg_pkg::StClear: begin
        cmd_o.wr_src  = tlg_pkg::WrZero;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.sweep_end) begin
          state_d = tlg_pkg::StFinish;
        end
      end
      tlg_pkg::StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = tlg_pkg::StIdle;
        end
      end
      default: begin
        state_d = tlg_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tlg_dp.sv =====
// grid store, row window, life lanes, config registers and result register
`default_nettype none

module tlg_dp #(
  parameter int unsigned MAX_ROWS    = tlg_pkg::DefaultMaxRows,
  parameter int unsigned MAX_COLUMNS = tlg_pkg::DefaultMaxColumns
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_index_i,
  input  wire logic [tlg_pkg::CfgWidth-1:0]     cfg_data_i,
  input  wire logic [1:0]                       op_i,
  input  wire logic [tlg_pkg::RowWidth-1:0]     row_i,
  input  wire logic [tlg_pkg::ColumnWidth-1:0]  column_i,
  input  wire logic                             value_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic                                  cell_state_o,
  output logic [1:0]                            op_done_o,
  input  wire tlg_pkg::cmd_t                    cmd_i,
  output tlg_pkg::sts_t                         sts_o
);

  localparam int unsigned AW  = $clog2(MAX_ROWS);
  localparam int unsigned CIW = $clog2(MAX_COLUMNS);
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW = $clog2(MAX_COLUMNS + 1);

  logic [tlg_pkg::CfgWidth-1:0]    rows_q, cols_q;
  tlg_pkg::op_e                    op_q;
  logic [tlg_pkg::RowWidth-1:0]    row_q;
  logic [tlg_pkg::ColumnWidth-1:0] col_q;
  logic                            val_q;
  logic [AW-1:0]                   cnt_q;
  logic [MAX_COLUMNS-1:0]          prev_q, cur_q, first_q;
  logic                            res_q;
  logic                            out_valid_q;
  logic                            cell_state_q;
  tlg_pkg::op_e                    op_done_q;

  logic [RCW-1:0]         nr;
  logic [CCW-1:0]         nc;
  logic [CIW-1:0]         nc_m1;
  logic                   in_area;
  logic                   row_end;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic                   wr_en;
  logic [MAX_COLUMNS-1:0] wr_data, rd_data, cell_word, next_w, new_row;
  logic                   up_end, md_end, dn_end;

  // effective active counts
  always_comb begin
    if (rows_q == '0) begin
      nr = RCW'(1);
    end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
      nr = RCW'(MAX_ROWS);
    end else begin
      nr = RCW'(rows_q);
    end
    if (cols_q == '0) begin
      nc = CCW'(1);
    end else if (32'(cols_q) > 32'(MAX_COLUMNS)) begin
      nc = CCW'(MAX_COLUMNS);
    end else begin
      nc = CCW'(cols_q);
    end
  end

  assign nc_m1   = CIW'(nc - CCW'(1));
  assign in_area = (32'(row_q) < 32'(nr)) && (32'(col_q) < 32'(nc));
  assign row_end = (RCW'(cnt_q) == (nr - RCW'(1)));

  assign sts_o.op        = op_q;
  assign sts_o.sweep_end = (cnt_q == AW'(MAX_ROWS - 1));
  assign sts_o.row_end   = row_end;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // read address select
  always_comb begin
    case (cmd_i.rd_src)
      tlg_pkg::RdCell:      rd_addr = AW'(row_q);
      tlg_pkg::RdLastRow:   rd_addr = AW'(nr - RCW'(1));
      tlg_pkg::RdFirstRow:  rd_addr = '0;
      tlg_pkg::RdSecondRow: rd_addr = AW'(1);
      tlg_pkg::RdAhead:     rd_addr = cnt_q + AW'(2);
      default:              rd_addr = '0;
    endcase
  end

  always_comb begin
    cell_word                = rd_data;
    cell_word[CIW'(col_q)]   = val_q;
  end

  // write port select
  always_comb begin
    case (cmd_i.wr_src)
      tlg_pkg::WrZero: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q;
        wr_data = '0;
      end
      tlg_pkg::WrCell: begin
        wr_en   = in_area;
        wr_addr = AW'(row_q);
        wr_data = cell_word;
      end
      tlg_pkg::WrGen: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q;
        wr_data = new_row;
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = cnt_q;
        wr_data = '0;
      end
    endcase
  end

  tlg_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // row below wraps to the saved first row on the last active row
  assign next_w = row_end ? first_q : rd_data;
  assign up_end = prev_q[nc_m1];
  assign md_end = cur_q[nc_m1];
  assign dn_end = next_w[nc_m1];

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_lane
    localparam int unsigned Lft = (c == 0) ? MAX_COLUMNS - 1 : c - 1;
    localparam int unsigned Rgt = (c == MAX_COLUMNS - 1) ? 0 : c + 1;
    logic       at_last, active;
    logic       up_l, up_r, md_l, md_r, dn_l, dn_r;
    logic [3:0] count;

    assign at_last = (CCW'(c + 1) == nc);
    assign active  = (CCW'(c) < nc);
    assign up_l    = (c == 0) ? up_end : prev_q[Lft];
    assign md_l    = (c == 0) ? md_end : cur_q[Lft];
    assign dn_l    = (c == 0) ? dn_end : next_w[Lft];
    assign up_r    = at_last ? prev_q[0] : prev_q[Rgt];
    assign md_r    = at_last ? cur_q[0] : cur_q[Rgt];
    assign dn_r    = at_last ? next_w[0] : next_w[Rgt];
    assign count   = 4'(up_l) + 4'(prev_q[c]) + 4'(up_r) + 4'(md_l) + 4'(md_r)
                   + 4'(dn_l) + 4'(next_w[c]) + 4'(dn_r);
    assign new_row[c] = active ? tlg_pkg::life_next(cur_q[c], count) : cur_q[c];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= tlg_pkg::CfgCountReset;
      cols_q      <= tlg_pkg::CfgCountReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (tlg_pkg::cfg_idx_e'(cfg_index_i))
          tlg_pkg::CfgRows:    rows_q <= cfg_data_i;
          tlg_pkg::CfgColumns: cols_q <= cfg_data_i;
          default:             ;
        endcase
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= (cnt_q == AW'(MAX_ROWS - 1)) ? '0 : cnt_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= tlg_pkg::op_e'(op_i);
      row_q <= row_i;
      col_q <= column_i;
      val_q <= value_i;
      res_q <= 1'b0;
    end else if (cmd_i.res_cell) begin
      res_q <= in_area & rd_data[CIW'(col_q)];
    end
    if (cmd_i.win_prev) begin
      prev_q <= rd_data;
    end else if (cmd_i.win_shift) begin
      prev_q <= cur_q;
    end
    if (cmd_i.win_first) begin
      cur_q   <= rd_data;
      first_q <= rd_data;
    end else if (cmd_i.win_shift) begin
      cur_q <= next_w;
    end
    if (cmd_i.out_load) begin
      cell_state_q <= res_q;
      op_done_q    <= op_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_state_o = cell_state_q;
  assign op_done_o    = op_done_q;

endmodule

`default_nettype wire

// ===== rtl/toroidal_life_generation_engine.sv =====
// top level: toroidal life grid with cell access, clear and generation step
// a cell write or read reads the row word, then writes it back or registers the bit;
// a generation reads the last, first and second rows, then one new row word per cycle
// through the ram; a clear zeroes all MAX_ROWS rows; one item in flight, and input
// is accepted again in the cycle that the result goes valid, once the output is free
// reset: a pass over all MAX_ROWS rows zeroes the grid ram, in_ready_o low; counts reset to 64
`default_nettype none

module toroidal_life_generation_engine #(
  parameter int unsigned MAX_ROWS    = tlg_pkg::DefaultMaxRows,
  parameter int unsigned MAX_COLUMNS = tlg_pkg::DefaultMaxColumns
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_index_i,
  input  wire logic [tlg_pkg::CfgWidth-1:0]     cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       op_i,
  input  wire logic [tlg_pkg::RowWidth-1:0]     row_i,
  input  wire logic [tlg_pkg::ColumnWidth-1:0]  column_i,
  input  wire logic                             value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  cell_state_o,
  output logic [1:0]                            op_done_o
);

  tlg_pkg::cmd_t cmd;
  tlg_pkg::sts_t sts;

  tlg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tlg_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .value_i      (value_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .cell_state_o (cell_state_o),
    .op_done_o    (op_done_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/tlg_checker.sv =====
// port-level checker for the generation engine and its bind
`default_nettype none

`include "toroidal_life_generation_engine_macros.svh"

module tlg_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       cell_state_o,
  input wire logic [1:0] op_done_o
);

  logic non_read_result;
  logic out_stall;

  assign non_read_result = out_valid_o && (op_done_o != tlg_pkg::OpRead);
  assign out_stall       = out_valid_o && !out_ready_i;

  // one item at a time: busy right after an input beat
  `TLG_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // a result appears together with the return to accepting input
  `TLG_ASSERT(a_result_frees_input, clk_i, rst_ni, $rose(out_valid_o) |-> in_ready_o)

  // only a read carries a cell value
  `TLG_ASSERT(a_value_only_on_read, clk_i, rst_ni, non_read_result |-> !cell_state_o)

  // stalled result holds
  `TLG_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_stall, out_valid_o && $stable({op_done_o, cell_state_o}))

endmodule

bind toroidal_life_generation_engine tlg_checker u_tlg_checker (.*);

`default_nettype wire

// ===== tb/toroidal_life_generation_engine_tb.sv =====
// self-checking testbench for the toroidal life engine: random cell ops, generations, clears and sizes
`default_nettype none

module toroidal_life_generation_engine_tb;
  import tlg_pkg::*;

  localparam int GridRows    = 64;
  localparam int GridColumns = 64;
  localparam int ItemsTotal  = 1950;
  localparam int QuietItems  = 300;
  localparam int CycleLimit  = 1000000;

  typedef struct packed {
    logic cell_bit;
    op_e  op_done;
  } life_result_t;

  class life_scoreboard;
    logic [GridColumns-1:0] grid [GridRows];
    logic [CfgWidth-1:0]    rows_cfg;
    logic [CfgWidth-1:0]    cols_cfg;
    life_result_t           due_results [$];
    int                     errors;

    function new();
      foreach (grid[r]) grid[r] = '0;
      rows_cfg = CfgCountReset;
      cols_cfg = CfgCountReset;
      errors   = 0;
    endfunction

    function int active_count(input logic [CfgWidth-1:0] count, input int limit);
      int n;
      n = int'(count);
      if (n == 0) n = 1;
      if (n > limit) n = limit;
      return n;
    endfunction

    function void step_generation();
      logic [GridColumns-1:0] nxt_rows [GridRows];
      int nr, nc, n, rr, cc;
      nr = active_count(rows_cfg, GridRows);
      nc = active_count(cols_cfg, GridColumns);
      nxt_rows = grid;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          n = 0;
          // each wrapped offset counts, even when it lands on the same cell again
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0) begin
                rr = (r + nr + dr) % nr;
                cc = (c + nc + dc) % nc;
                n += int'(grid[rr][cc]);
              end
            end
          end
          if (grid[r][c]) nxt_rows[r][c] = (n == 2) || (n == 3);
          else nxt_rows[r][c] = (n == 3);
        end
      end
      grid = nxt_rows;
    endfunction

    function void note_beat(input op_e op, input logic [RowWidth-1:0] row,
                            input logic [ColumnWidth-1:0] col, input logic val);
      life_result_t res;
      logic in_area;
      in_area = (int'(row) < active_count(rows_cfg, GridRows)) &&
                (int'(col) < active_count(cols_cfg, GridColumns));
      res.cell_bit = 1'b0;
      res.op_done  = op;
      case (op)
        OpWrite: begin
          if (in_area) grid[row][col] = val;
        end
        OpRead: begin
          if (in_area) res.cell_bit = grid[row][col];
        end
        OpAdvance: begin
          step_generation();
        end
        default: begin
          foreach (grid[r]) grid[r] = '0;
        end
      endcase
      due_results.push_back(res);
    endfunction

    function void check_result(input logic cell_bit, input logic [1:0] op_done);
      life_result_t exp_res;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat, cell_state %0b op_done %0d",
                 $time, cell_bit, op_done);
        errors++;
      end else begin
        exp_res = due_results.pop_front();
        if (cell_bit !== exp_res.cell_bit) begin
          $display("%0t: cell_state mismatch, expected %0b actual %0b",
                   $time, exp_res.cell_bit, cell_bit);
          errors++;
        end
        if (op_done !== exp_res.op_done) begin
          $display("%0t: op_done mismatch, expected %0d actual %0d",
                   $time, exp_res.op_done, op_done);
          errors++;
        end
      end
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic                   cfg_index_i = 1'b0;
  logic [CfgWidth-1:0]    cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             op_i        = '0;
  logic [RowWidth-1:0]    row_i       = '0;
  logic [ColumnWidth-1:0] column_i    = '0;
  logic                   value_i     = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   cell_state_o;
  logic [1:0]             op_done_o;

  life_scoreboard sb = new();
  bit idle_on = 1'b1;
  int items_sent = 0;
  int cycle_count = 0;

  toroidal_life_generation_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_state_o(cell_state_o),
    .op_done_o   (op_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(cell_state_o, op_done_o);
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 20)) @(posedge clk_i);
    end
  end

  task automatic send_op(input op_e op, input logic [RowWidth-1:0] row,
                         input logic [ColumnWidth-1:0] col, input logic val);
    int gap;
    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_i       <= op;
    row_i      <= row;
    column_i   <= col;
    value_i    <= val;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(op, row, col, val);
    items_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_counts(input logic [CfgWidth-1:0] rows, input logic [CfgWidth-1:0] cols);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgRows;
    cfg_data_i  <= rows;
    @(posedge clk_i);
    sb.rows_cfg = rows;
    cfg_index_i <= CfgColumns;
    cfg_data_i  <= cols;
    @(posedge clk_i);
    sb.cols_cfg = cols;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CfgWidth-1:0] pick_count();
    logic [CfgWidth-1:0] count;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: count = 7'd0;
          1: count = 7'd1;
          2: count = 7'd2;
          3: count = 7'd3;
          default: count = 7'd64;
        endcase
      end
      1: count = 7'($urandom_range(65, 127));
      default: count = 7'($urandom_range(1, 10));
    endcase
    return count;
  endfunction

  task automatic random_cell(input int nr, input int nc, output logic [RowWidth-1:0] row,
                             output logic [ColumnWidth-1:0] col);
    if ($urandom_range(0, 9) == 0) begin
      row = 6'($urandom);
      col = 6'($urandom);
    end else begin
      row = 6'($urandom_range(0, nr - 1));
      col = 6'($urandom_range(0, nc - 1));
    end
  endtask

  initial begin
    logic [CfgWidth-1:0]    rows, cols;
    logic [RowWidth-1:0]    row;
    logic [ColumnWidth-1:0] col;
    int nr, nc, fill, pick;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cells on the full grid, then a blinker on a small torus
    set_counts(7'd64, 7'd64);
    send_op(OpRead, 6'd0, 6'd0, 1'b0);
    send_op(OpWrite, 6'd63, 6'd63, 1'b1);
    send_op(OpRead, 6'd63, 6'd63, 1'b0);
    send_op(OpWrite, 6'd40, 6'd40, 1'b1);
    send_op(OpWrite, 6'd0, 6'd0, 1'b1);
    wait_results_drained();
    set_counts(7'd5, 7'd5);
    send_op(OpRead, 6'd40, 6'd40, 1'b0);
    send_op(OpWrite, 6'd6, 6'd1, 1'b1);
    send_op(OpWrite, 6'd2, 6'd1, 1'b1);
    send_op(OpWrite, 6'd2, 6'd2, 1'b1);
    send_op(OpWrite, 6'd2, 6'd3, 1'b1);
    send_op(OpAdvance, 6'd63, 6'd63, 1'b1);
    send_op(OpRead, 6'd1, 6'd2, 1'b0);
    send_op(OpRead, 6'd2, 6'd1, 1'b0);
    // zero and oversized counts, single row and single column tori
    wait_results_drained();
    set_counts(7'd0, 7'd127);
    send_op(OpWrite, 6'd0, 6'd5, 1'b1);
    send_op(OpAdvance, 6'd0, 6'd0, 1'b0);
    send_op(OpRead, 6'd0, 6'd5, 1'b0);
    wait_results_drained();
    set_counts(7'd127, 7'd0);
    send_op(OpAdvance, 6'd0, 6'd0, 1'b0);
    send_op(OpRead, 6'd40, 6'd0, 1'b0);
    wait_results_drained();
    set_counts(7'd64, 7'd64);
    send_op(OpRead, 6'd40, 6'd40, 1'b0);
    send_op(OpClear, 6'd21, 6'd42, 1'b1);
    send_op(OpRead, 6'd0, 6'd0, 1'b0);

    while (items_sent < ItemsTotal) begin
      if (items_sent >= ItemsTotal - QuietItems) idle_on = 1'b0;
      wait_results_drained();
      rows = pick_count();
      cols = pick_count();
      set_counts(rows, cols);
      nr = sb.active_count(rows, GridRows);
      nc = sb.active_count(cols, GridColumns);
      if ($urandom_range(0, 1) == 0) send_op(OpClear, 6'($urandom), 6'($urandom), 1'($urandom));
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(10, 30))
          send_op(op_e'($urandom_range(0, 3)), 6'($urandom), 6'($urandom), 1'($urandom));
      end else begin
        fill = (nr * nc > 48) ? 48 : nr * nc;
        fill = $urandom_range(fill / 3, fill);
        repeat (fill) begin
          random_cell(nr, nc, row, col);
          send_op(OpWrite, row, col, $urandom_range(0, 9) < 4);
        end
        repeat ($urandom_range(8, 30)) begin
          pick = $urandom_range(0, 99);
          random_cell(nr, nc, row, col);
          if (pick < 35) send_op(OpAdvance, row, col, 1'($urandom));
          else if (pick < 85) send_op(OpRead, row, col, 1'($urandom));
          else if (pick < 97) send_op(OpWrite, row, col, 1'($urandom));
          else send_op(OpClear, row, col, 1'($urandom));
        end
      end
    end

    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/tlg_pkg.sv
rtl/tlg_ram.sv
rtl/tlg_ctrl.sv
rtl/tlg_dp.sv
rtl/toroidal_life_generation_engine.sv
rtl/tlg_checker.sv
tb/toroidal_life_generation_engine_tb.sv
